// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Every check samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define ASSERT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a sampled edge.
`define ASSERT_NEVER(lbl, expr, msg) \
    `ASSERT_CHECK(lbl, !(expr), msg)

`endif

// ===== rtl/bblur_pkg.sv =====
package bblur_pkg;

    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int WIN_SIDE    = 3;
    localparam int WIN_N       = WIN_SIDE * WIN_SIDE;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int X_W         = SUM_W + 1;
    localparam int RCP_W       = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = X_W + RCP_W;

    localparam int FW_W      = 11;
    localparam int FH_W      = 16;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN_N-1:0] win_t;

    // Control word handed to the mean unit along with the window.
    typedef struct packed {
        logic [WIN_N-1:0] mask;
        logic             last;
    } job_t;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_FRAME_WIDTH  = 1'b0;
    localparam reg_idx_t REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd768;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // ceil(2^RECIP_SHIFT / (2n)); exact for every dividend below 2*9*255+9+1.
    function automatic logic [RCP_W-1:0] recip_mul(input logic [CNT_W-1:0] n);
        logic [RCP_W-1:0] m;
        case (n)
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = 18'd131072;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/bblur_mean.sv =====
`include "assert_macros.svh"

module bblur_mean
    import bblur_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  job_t            job,
    input  win_t            win,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [CH_W-1:0] red,
    output logic [CH_W-1:0] green,
    output logic [CH_W-1:0] blue,
    output logic            last
);

    // channel 0 = blue (low byte), 2 = red
    logic [2:0][SUM_W-1:0] sum_a;
    logic [CNT_W-1:0]      cnt_a;

    logic                  a_valid_reg;
    logic [2:0][SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  a_last_reg;

    logic [RCP_W-1:0]      rcp;
    logic [2:0][X_W-1:0]   x_val;
    logic [2:0][PROD_W-1:0] prod;
    logic [2:0][CH_W-1:0]  mean;

    logic                  o_valid_reg;
    logic [2:0][CH_W-1:0]  o_chan_reg;
    logic                  o_last_reg;

    logic                  o_en;
    logic                  a_en;

    assign o_en      = !o_valid_reg || res_ready;
    assign job_ready = !a_valid_reg || o_en;
    assign a_en      = job_valid && job_ready;

    // masked window sum
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_a[ch] = '0;
            for (int e = 0; e < WIN_N; e++)
            begin
                sum_a[ch] = sum_a[ch]
                          + SUM_W'(job.mask[e] ? win[e][ch*CH_W +: CH_W] : '0);
            end
        end
        cnt_a = CNT_W'($countones(job.mask));
    end

    // rounded mean: (2s + n) / (2n) by reciprocal multiply
    always_comb
    begin
        rcp = recip_mul(cnt_reg);
        for (int ch = 0; ch < 3; ch++)
        begin
            x_val[ch] = {sum_reg[ch], 1'b0} + X_W'(cnt_reg);
            prod[ch]  = PROD_W'(x_val[ch]) * PROD_W'(rcp);
            mean[ch]  = prod[ch][RECIP_SHIFT +: CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                a_valid_reg <= job_valid;
            end
            if (o_en)
            begin
                o_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            sum_reg    <= sum_a;
            cnt_reg    <= cnt_a;
            a_last_reg <= job.last;
        end
        if (o_en && a_valid_reg)
        begin
            o_chan_reg <= mean;
            o_last_reg <= a_last_reg;
        end
    end

    assign res_valid = o_valid_reg;
    assign red       = o_chan_reg[2];
    assign green     = o_chan_reg[1];
    assign blue      = o_chan_reg[0];
    assign last      = o_last_reg;

    `ASSERT_NEVER(a_mean_count_range, a_valid_reg && (cnt_reg == '0 || cnt_reg > CNT_W'(WIN_N)), "mean job with no or too many pixels")

endmodule

// ===== rtl/box_blur_3x3_edge_average.sv =====
// Channel   | Dir | Handshake           | Word
// ----------+-----+---------------------+--------------------------------------
// input     | in  | in_valid/in_ready   | cmd, red_in, green_in, blue_in
// output    | out | out_valid/out_ready | red_out, green_out, blue_out, frame_last
// config    | in  | APB psel/penable    | paddr 0: frame_width, 4: frame_height
//
// One input word at a time. A pixel word passes S_IDLE and S_LOAD, then one emit
// state per result it releases (0, 1 or 2); a drain word passes S_IDLE, an S_LOAD
// step per column and S_EMIT_A. The line stores have a single read port, so a drain
// word walks three columns through it. Results pass a two-stage mean unit (sum,
// then reciprocal multiply) that holds two results, and once both wait on
// out_ready the sequencer holds in its emit state.
// Line stores are not cleared at reset: entries never written are always
// masked out. Reset clears counters and sets width 1024, height 768.
`include "assert_macros.svh"

module box_blur_3x3_edge_average
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [CH_W-1:0]   red_in,
    input  logic [CH_W-1:0]   green_in,
    input  logic [CH_W-1:0]   blue_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CH_W-1:0]   red_out,
    output logic [CH_W-1:0]   green_out,
    output logic [CH_W-1:0]   blue_out,
    output logic              frame_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // column index bits, bits to hold a width value
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > FW_W) ? WW : FW_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_EMIT_A = 4'b0100,
        S_EMIT_B = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [FW_W-1:0]       fw_reg, fw_next;
    logic [FH_W-1:0]       fh_reg, fh_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [FH_W-1:0]       row_reg, row_next;
    logic [CW-1:0]         drain_reg, drain_next;
    logic [1:0]            load_left_reg, load_left_next;
    logic                  pix_item_reg, pix_item_next;
    logic                  emit_a_reg, emit_a_next;
    logic                  emit_b_reg, emit_b_next;
    logic                  last_reg, last_next;

    // per-word payload
    logic [CW-1:0]         addr_reg, addr_next;
    pix_t                  px_reg, px_next;
    logic [WIN_SIDE-1:0]   rmask_reg, rmask_next;
    logic [WIN_SIDE-1:0]   cmask_a_reg, cmask_a_next;
    logic [WIN_SIDE-1:0]   cmask_b_reg, cmask_b_next;
    win_t                  win_reg, win_next;

    // line stores: upper holds row r-2, middle row r-1, per column
    pix_t                  upper_mem [MAX_WIDTH];
    pix_t                  middle_mem [MAX_WIDTH];
    pix_t                  rd_up_reg;
    pix_t                  rd_mid_reg;
    logic                  mem_re;
    logic                  mem_we;
    logic [CW-1:0]         rd_addr;

    logic [EW-1:0]         fw_ext;
    logic [EW-1:0]         eff_w;
    logic [FH_W-1:0]       eff_h;
    logic [EW-1:0]         col_inc;
    logic [EW-1:0]         drn_inc;

    logic                  in_acc;
    logic                  pix_go;
    logic                  drn_go;
    logic                  cfg_we;
    reg_idx_t              reg_idx;

    logic                  job_valid;
    logic                  job_ready;
    job_t                  job;

    // ---------------------------------------------------------------
    // Effective frame size: width 0 acts as 1, clipped to MAX_WIDTH;
    // height 0 acts as 1.
    // ---------------------------------------------------------------
    always_comb
    begin
        fw_ext = EW'(fw_reg);
        if (fw_reg == '0)
        begin
            eff_w = EW'(1);
        end
        else if (fw_ext > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_ext;
        end
    end

    assign eff_h   = (fh_reg == '0) ? FH_W'(1) : fh_reg;
    assign col_inc = EW'(col_reg) + EW'(1);
    assign drn_inc = EW'(drain_reg) + EW'(1);

    // ---------------------------------------------------------------
    // Handshakes. A pixel word after the last row, or a drain word
    // before the frame is complete, is taken and dropped.
    // ---------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign pix_go   = in_acc && (cmd == CMD_PIXEL) && (row_reg < eff_h);
    assign drn_go   = in_acc && (cmd == CMD_DRAIN) && (row_reg == eff_h);

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(fw_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(fh_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Line store access. A pixel reads its column on acceptance and
    // writes it back in S_LOAD (upper <- old middle, middle <- pixel).
    // A drain reads columns d-1, d, d+1 on successive cycles and never
    // writes, so a read and a write never share a cycle.
    // ---------------------------------------------------------------
    assign mem_re = pix_go || drn_go || ((state_reg == S_LOAD) && (load_left_reg != '0));
    assign mem_we = (state_reg == S_LOAD) && pix_item_reg;

    always_comb
    begin
        if (state_reg == S_LOAD)
        begin
            rd_addr = addr_reg + CW'(1);
        end
        else if (cmd == CMD_DRAIN)
        begin
            rd_addr = drain_reg - CW'(1);
        end
        else
        begin
            rd_addr = col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            upper_mem[addr_reg]  <= rd_mid_reg;
            middle_mem[addr_reg] <= px_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_up_reg  <= upper_mem[rd_addr];
            rd_mid_reg <= middle_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // 3x3 window: element i*3+k is row (r-2+i), column (c-2+k).
    // Every S_LOAD cycle shifts one column in from the read data.
    // In a drain the bottom row is stale and always masked.
    // ---------------------------------------------------------------
    always_comb
    begin
        win_next = win_reg;
        if (state_reg == S_LOAD)
        begin
            for (int i = 0; i < WIN_SIDE; i++)
            begin
                win_next[i*WIN_SIDE]     = win_reg[i*WIN_SIDE + 1];
                win_next[i*WIN_SIDE + 1] = win_reg[i*WIN_SIDE + 2];
            end
            win_next[WIN_SIDE - 1]     = rd_up_reg;
            win_next[2*WIN_SIDE - 1]   = rd_mid_reg;
            win_next[WIN_N - 1]        = px_reg;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer. Row and column masks are worked out on acceptance:
    //   result A (pixel): output (r-1, c-1), full window columns,
    //     left column only from c >= 2, top row only from r >= 2;
    //   result B (pixel, last column): output (r-1, c), right
    //     edge, so window column 0 is out and column 1 needs c >= 1;
    //   drain: output (h-1, d), top row only when h >= 2, no bottom
    //     row, edges masked at d = 0 and d = w-1.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        drain_next     = drain_reg;
        load_left_next = load_left_reg;
        pix_item_next  = pix_item_reg;
        emit_a_next    = emit_a_reg;
        emit_b_next    = emit_b_reg;
        last_next      = last_reg;
        addr_next      = addr_reg;
        px_next        = px_reg;
        rmask_next     = rmask_reg;
        cmask_a_next   = cmask_a_reg;
        cmask_b_next   = cmask_b_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (pix_go)
                begin
                    px_next        = {red_in, green_in, blue_in};
                    addr_next      = col_reg;
                    load_left_next = '0;
                    pix_item_next  = 1'b1;
                    rmask_next     = {1'b1, 1'b1, row_reg >= FH_W'(2)};
                    cmask_a_next   = {1'b1, 1'b1, EW'(col_reg) >= EW'(2)};
                    cmask_b_next   = {1'b1, col_reg != '0, 1'b0};
                    emit_a_next    = (row_reg != '0) && (col_reg != '0);
                    emit_b_next    = (row_reg != '0) && (col_inc == eff_w);
                    last_next      = 1'b0;
                    if (col_inc >= eff_w)
                    begin
                        col_next = '0;
                        row_next = row_reg + FH_W'(1);
                    end
                    else
                    begin
                        col_next = col_inc[CW-1:0];
                    end
                    state_next = S_LOAD;
                end
                else if (drn_go)
                begin
                    addr_next      = drain_reg - CW'(1);
                    load_left_next = 2'd2;
                    pix_item_next  = 1'b0;
                    rmask_next     = {1'b0, 1'b1, eff_h >= FH_W'(2)};
                    cmask_a_next   = {drn_inc < eff_w, 1'b1, drain_reg != '0};
                    cmask_b_next   = '0;
                    emit_a_next    = 1'b1;
                    emit_b_next    = 1'b0;
                    last_next      = (drn_inc == eff_w);
                    if (drn_inc >= eff_w)
                    begin
                        // frame done, ready for the next one
                        drain_next = '0;
                        row_next   = '0;
                        col_next   = '0;
                    end
                    else
                    begin
                        drain_next = drn_inc[CW-1:0];
                    end
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                if (load_left_reg != '0)
                begin
                    addr_next      = addr_reg + CW'(1);
                    load_left_next = load_left_reg - 2'd1;
                end
                else if (emit_a_reg)
                begin
                    state_next = S_EMIT_A;
                end
                else if (emit_b_reg)
                begin
                    state_next = S_EMIT_B;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_EMIT_A:
            begin
                if (job_ready)
                begin
                    state_next = emit_b_reg ? S_EMIT_B : S_IDLE;
                end
            end

            S_EMIT_B:
            begin
                if (job_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // any register write restarts the frame
        if (cfg_we)
        begin
            case (reg_idx)
                REG_FRAME_WIDTH:  fw_next = pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_next = pwdata[FH_W-1:0];
                default:          fw_next = fw_reg;
            endcase
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fw_reg        <= FRAME_WIDTH_RST;
            fh_reg        <= FRAME_HEIGHT_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            drain_reg     <= '0;
            load_left_reg <= '0;
            pix_item_reg  <= 1'b0;
            emit_a_reg    <= 1'b0;
            emit_b_reg    <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            drain_reg     <= drain_next;
            load_left_reg <= load_left_next;
            pix_item_reg  <= pix_item_next;
            emit_a_reg    <= emit_a_next;
            emit_b_reg    <= emit_b_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        px_reg      <= px_next;
        rmask_reg   <= rmask_next;
        cmask_a_reg <= cmask_a_next;
        cmask_b_reg <= cmask_b_next;
        win_reg     <= win_next;
    end

    // ---------------------------------------------------------------
    // Job to the mean unit: in-frame mask = row mask x column mask.
    // ---------------------------------------------------------------
    assign job_valid = (state_reg == S_EMIT_A) || (state_reg == S_EMIT_B);

    always_comb
    begin
        for (int i = 0; i < WIN_SIDE; i++)
        begin
            for (int k = 0; k < WIN_SIDE; k++)
            begin
                job.mask[i*WIN_SIDE + k] = rmask_reg[i]
                    & ((state_reg == S_EMIT_B) ? cmask_b_reg[k] : cmask_a_reg[k]);
            end
        end
        job.last = last_reg && (state_reg == S_EMIT_A);
    end

    bblur_mean u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .win       (win_reg),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .red       (red_out),
        .green     (green_out),
        .blue      (blue_out),
        .last      (frame_last)
    );

    `ASSERT_NEVER(a_mem_rw_same_cycle, mem_we && mem_re, "line store read and write in one cycle")
    `ASSERT_NEVER(a_row_past_height, row_reg > eff_h, "row count beyond frame height")
    `ASSERT_NEVER(a_col_past_width, EW'(col_reg) >= eff_w, "column count beyond frame width")
    `ASSERT_CHECK(a_drain_when_full, (drain_reg != '0) |-> (row_reg == eff_h), "drain running before frame complete")

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import bblur_pkg::*;

    // Line store depth of the instance; the predictor mirrors it.
    localparam int MAXW = 1024;

    // Slowest correct run: at most about 2700 words (a random phase may overshoot its
    // share), each through the block's sequencer with up to 2 results, each result held
    // up by the receiver's ready pattern, plus random sender gaps; the watchdog allows
    // several times the slowest run.
    localparam int WATCHDOG_CYCLES = 2_500_000;

    // Quiet cycles after the last expected word before touching the registers or ending:
    // enough for a drain word to pass the sequencer and the mean unit, so ignored words too.
    localparam int SETTLE_CYCLES = 24;

    localparam logic [CH_W-1:0] CH_MAX = '1;
    localparam logic [CH_W-1:0] CH_MIN = '0;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } out_word_t;

    // Every block input starts at a known value.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              cmd       = CMD_PIXEL;
    logic [CH_W-1:0]   red_in    = '0;
    logic [CH_W-1:0]   green_in  = '0;
    logic [CH_W-1:0]   blue_in   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic              frame_last;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    box_blur_3x3_edge_average #(
        .MAX_WIDTH (MAXW)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_last (frame_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Blur predictor: its own copy of registers, line stores, window and
    // the raster position of the next pixel / drain column.
    // ------------------------------------------------------------------
    logic [FW_W-1:0] cfg_width;
    logic [FH_W-1:0] cfg_height;
    pix_t            rows_up  [MAXW];   // row two above the incoming pixel
    pix_t            rows_mid [MAXW];   // row just above
    pix_t            win_px   [WIN_N];  // row-major 3x3, column 2 is the newest
    int              next_col;
    int              next_row;
    int              drain_col;

    out_word_t       expected_px [$];   // blurred words still owed by the block
    in_word_t        pending_words [$]; // words waiting for the driver

    int              words_queued   = 0;
    int              words_accepted = 0;
    int              words_checked  = 0;
    int              frames_done    = 0;
    int              reg_writes     = 0;
    int              mismatches     = 0;
    bit              sender_bursty   = 1'b0;
    bit              receiver_stalls = 1'b0;

    function automatic void clear_blur_state();
        cfg_width  = FRAME_WIDTH_RST;
        cfg_height = FRAME_HEIGHT_RST;
        for (int i = 0; i < MAXW; i++) begin
            rows_up[i]  = '0;
            rows_mid[i] = '0;
        end
        for (int i = 0; i < WIN_N; i++)
            win_px[i] = '0;
        next_col  = 0;
        next_row  = 0;
        drain_col = 0;
    endfunction

    // Out-of-range register values: width 0 acts as 1, above the store depth as the depth;
    // height 0 acts as 1.
    function automatic int eff_w();
        if (cfg_width == 0)
            return 1;
        if (int'(cfg_width) > MAXW)
            return MAXW;
        return int'(cfg_width);
    endfunction

    function automatic int eff_h();
        return (cfg_height == 0) ? 1 : int'(cfg_height);
    endfunction

    function automatic void add_px(inout int sr, inout int sg, inout int sb, input pix_t p);
        sr += int'(p[2*CH_W +: CH_W]);
        sg += int'(p[CH_W +: CH_W]);
        sb += int'(p[0 +: CH_W]);
    endfunction

    // Mean with halves rounded up: (2*sum + n) / (2*n).
    function automatic out_word_t rounded_mean(int sr, int sg, int sb, int n, logic last);
        out_word_t o;
        o.red   = CH_W'((2 * sr + n) / (2 * n));
        o.green = CH_W'((2 * sg + n) / (2 * n));
        o.blue  = CH_W'((2 * sb + n) / (2 * n));
        o.last  = last;
        return o;
    endfunction

    // Window row i holds frame row r-2+i, column k holds frame column c-2+k.
    // Only taps inside the frame and next to (orow, ocol) count.
    function automatic out_word_t window_mean(int r, int c, int orow, int ocol);
        int w, h, rr, cc, n, sr, sg, sb;
        w  = eff_w();
        h  = eff_h();
        n  = 0;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int i = 0; i < WIN_SIDE; i++) begin
            for (int k = 0; k < WIN_SIDE; k++) begin
                rr = r - 2 + i;
                cc = c - 2 + k;
                if (rr >= 0 && rr < h && cc >= 0 && cc < w &&
                    rr >= orow - 1 && rr <= orow + 1 && cc >= ocol - 1 && cc <= ocol + 1)
                begin
                    add_px(sr, sg, sb, win_px[i * WIN_SIDE + k]);
                    n++;
                end
            end
        end
        return rounded_mean(sr, sg, sb, n, 1'b0);
    endfunction

    function automatic void predict_word(in_word_t wd);
        int   w, h, r, c, d, sr, sg, sb, n;
        pix_t up_px, mid_px;
        w = eff_w();
        h = eff_h();
        if (wd.cmd == CMD_DRAIN) begin
            // Drain before the last pixel, or with nothing left to release: ignored.
            d = drain_col;
            if (next_row != h || d >= w)
                return;
            sr = 0;
            sg = 0;
            sb = 0;
            n  = 0;
            for (int cc = d - 1; cc <= d + 1; cc++) begin
                if (cc >= 0 && cc < w) begin
                    if (h >= 2) begin
                        add_px(sr, sg, sb, rows_up[cc]);
                        n++;
                    end
                    add_px(sr, sg, sb, rows_mid[cc]);
                    n++;
                end
            end
            expected_px.push_back(rounded_mean(sr, sg, sb, n, d == w - 1));
            drain_col = d + 1;
            if (drain_col >= w) begin
                drain_col = 0;
                next_row  = 0;
                next_col  = 0;
            end
            return;
        end
        // Pixel while the final row is still pending: ignored.
        if (next_row >= h)
            return;
        r      = next_row;
        c      = next_col;
        up_px  = rows_up[c];
        mid_px = rows_mid[c];
        for (int i = 0; i < WIN_SIDE; i++) begin
            win_px[i * WIN_SIDE]     = win_px[i * WIN_SIDE + 1];
            win_px[i * WIN_SIDE + 1] = win_px[i * WIN_SIDE + 2];
        end
        win_px[2]   = up_px;
        win_px[5]   = mid_px;
        win_px[8]   = {wd.red, wd.green, wd.blue};
        rows_up[c]  = mid_px;
        rows_mid[c] = {wd.red, wd.green, wd.blue};
        if (r >= 1) begin
            if (c >= 1)
                expected_px.push_back(window_mean(r, c, r - 1, c - 1));
            // Last column goes out together with its left neighbour.
            if (c == w - 1)
                expected_px.push_back(window_mean(r, c, r - 1, c));
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        next_col = c;
        next_row = r;
    endfunction

    // Any register write restarts the frame.
    function automatic void apply_reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        if (idx == REG_FRAME_WIDTH)
            cfg_width = value[FW_W-1:0];
        else
            cfg_height = value[FH_W-1:0];
        next_col  = 0;
        next_row  = 0;
        drain_col = 0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Channel values lean on the extremes so every bit sees both values.
    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0:       return CH_MIN;
            1:       return CH_MAX;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic pix_t rand_px();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    function automatic void queue_word(logic cmd_bit, pix_t px);
        in_word_t wd;
        wd.cmd   = cmd_bit;
        wd.red   = px[2*CH_W +: CH_W];
        wd.green = px[CH_W +: CH_W];
        wd.blue  = px[0 +: CH_W];
        pending_words.push_back(wd);
        words_queued++;
    endfunction

    // A frame in raster order, then its drain words. With fewer pixels than w*h the frame
    // is left unfinished (the next register write drops it). Noise: early drains among
    // the pixels and stray pixels among the drains, both ignored by the block.
    function automatic void queue_frame(int w, int h, int pixels, int noise_pct);
        for (int i = 0; i < pixels; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                queue_word(CMD_DRAIN, rand_px());
            queue_word(CMD_PIXEL, rand_px());
        end
        if (pixels < w * h)
            return;
        for (int d = 0; d < w; d++) begin
            if ($urandom_range(0, 99) < noise_pct)
                queue_word(CMD_PIXEL, rand_px());
            queue_word(CMD_DRAIN, rand_px());
        end
        frames_done++;
    endfunction

    // One APB transfer: setup cycle, access cycle, done at the edge with pready high.
    task automatic apb_xfer(input logic wr, input reg_idx_t idx,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(reg_idx_t idx);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] want;
        apb_xfer(1'b0, idx, '0, rd);
        want = (idx == REG_FRAME_WIDTH) ? DATA_W'(cfg_width) : DATA_W'(cfg_height);
        if (rd !== want) begin
            $error("prdata (reg %0d): expected %0d, got %0d", idx, want, rd);
            mismatches++;
        end
    endtask

    task automatic set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        apply_reg_write(idx, value);
        reg_writes++;
        check_reg(idx);
    endtask

    // Everything queued accepted, every owed word seen, then the block is given time
    // to finish words that produce nothing.
    task automatic wait_idle();
        while (words_accepted != words_queued || expected_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length with random gaps when sender_bursty,
    // otherwise a word every cycle the block takes one.
    // ------------------------------------------------------------------
    int       burst_left = 0;
    int       gap_left   = 0;
    in_word_t drive_word;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            cmd      <= CMD_PIXEL;
            red_in   <= '0;
            green_in <= '0;
            blue_in  <= '0;
        end
        else if (!in_valid || in_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0) begin
                drive_word = pending_words.pop_front();
                in_valid <= 1'b1;
                cmd      <= drive_word.cmd;
                red_in   <= drive_word.red;
                green_in <= drive_word.green;
                blue_in  <= drive_word.blue;
                if (sender_bursty) begin
                    if (burst_left > 0)
                        burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = $urandom_range(1, 6);
                    end
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a rotating 16-bit ready pattern, reloaded now and then, never all zero.
    // ------------------------------------------------------------------
    logic [15:0] ready_pattern = '1;
    int          pattern_age   = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (!receiver_stalls)
            out_ready <= 1'b1;
        else begin
            if (pattern_age == 0) begin
                ready_pattern = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
                pattern_age   = $urandom_range(16, 48);
            end
            else
                pattern_age--;
            out_ready     <= ready_pattern[0];
            ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input word, then check any output word
    // accepted at the same edge against the oldest expectation.
    // ------------------------------------------------------------------
    out_word_t want_px;

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                words_accepted++;
                predict_word({cmd, red_in, green_in, blue_in});
            end
            if (out_valid && out_ready) begin
                words_checked++;
                if (expected_px.size() == 0) begin
                    $error("output word with nothing expected: r=%0d g=%0d b=%0d last=%0b",
                           red_out, green_out, blue_out, frame_last);
                    mismatches++;
                end
                else begin
                    want_px = expected_px.pop_front();
                    if (red_out !== want_px.red) begin
                        $error("red_out: expected %0d, got %0d", want_px.red, red_out);
                        mismatches++;
                    end
                    if (green_out !== want_px.green) begin
                        $error("green_out: expected %0d, got %0d", want_px.green, green_out);
                        mismatches++;
                    end
                    if (blue_out !== want_px.blue) begin
                        $error("blue_out: expected %0d, got %0d", want_px.blue, blue_out);
                        mismatches++;
                    end
                    if (frame_last !== want_px.last) begin
                        $error("frame_last: expected %0b, got %0b", want_px.last, frame_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    int unsigned cycle_count = 0;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > WATCHDOG_CYCLES) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_px.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int w_val;
        int h_val;
        int random_start;
        int nframes;
        clear_blur_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values readable before anything is written.
        check_reg(REG_FRAME_WIDTH);
        check_reg(REG_FRAME_HEIGHT);

        // --- Directed: 3x3 frame, red all max, blue all zero, green alternating.
        // Center sees the largest sum; corners, edges and center cover divisors 4, 6, 9.
        set_reg(REG_FRAME_WIDTH, 32'd3);
        set_reg(REG_FRAME_HEIGHT, 32'd3);
        queue_word(CMD_DRAIN, {CH_MAX, CH_MAX, CH_MAX});      // early drain, ignored
        for (int i = 0; i < 9; i++)
            queue_word(CMD_PIXEL, {CH_MAX, (i % 2) ? CH_MAX : CH_MIN, CH_MIN});
        queue_word(CMD_DRAIN, rand_px());
        queue_word(CMD_PIXEL, {CH_MAX, CH_MAX, CH_MAX});      // pixel while row pending
        queue_word(CMD_DRAIN, rand_px());
        queue_word(CMD_DRAIN, rand_px());
        frames_done++;
        wait_idle();

        // Zero width and height act as 1: a single-pixel frame, divisor 1.
        set_reg(REG_FRAME_WIDTH, 32'd0);
        set_reg(REG_FRAME_HEIGHT, 32'd0);
        queue_word(CMD_DRAIN, rand_px());
        queue_frame(eff_w(), eff_h(), 1, 0);
        wait_idle();

        // Single row (drain divisor 2), then single column (divisors 2 and 3).
        receiver_stalls = 1'b1;
        set_reg(REG_FRAME_WIDTH, 32'd2);
        set_reg(REG_FRAME_HEIGHT, 32'd1);
        queue_frame(eff_w(), eff_h(), 2, 0);
        wait_idle();
        set_reg(REG_FRAME_WIDTH, 32'd1);
        set_reg(REG_FRAME_HEIGHT, 32'd3);
        queue_frame(eff_w(), eff_h(), 3, 0);
        wait_idle();

        // --- Random: mostly small whole frames, back to back, with random pixels.
        // Some phases carry ignored noise words, some end in an unfinished frame.
        random_start = words_queued;
        while (words_queued - random_start < 380) begin
            sender_bursty   = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: w_val = $urandom_range(1, 6);
                6, 7:             w_val = $urandom_range(7, 16);
                8:                w_val = $urandom_range(17, 40);
                default:          w_val = $urandom_range(0, 3);
            endcase
            h_val = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0)
                h_val = 0;
            case ($urandom_range(0, 3))
                0:       set_reg(REG_FRAME_WIDTH, w_val);
                1:       set_reg(REG_FRAME_HEIGHT, h_val);
                default: begin
                    set_reg(REG_FRAME_WIDTH, w_val);
                    set_reg(REG_FRAME_HEIGHT, h_val);
                end
            endcase
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++)
                queue_frame(eff_w(), eff_h(), eff_w() * eff_h(),
                            ($urandom_range(0, 3) == 0) ? 8 : 0);
            if ($urandom_range(0, 7) == 0 && eff_w() * eff_h() > 1)
                queue_frame(eff_w(), eff_h(), $urandom_range(1, eff_w() * eff_h() - 1), 5);
            wait_idle();
        end

        // --- Register extremes.
        // Width above the store depth reads back unclipped and runs as the depth;
        // only the start of the row is sent, the next write drops it.
        sender_bursty   = 1'b1;
        receiver_stalls = 1'b1;
        set_reg(REG_FRAME_WIDTH, 32'd2047);
        set_reg(REG_FRAME_HEIGHT, 32'd1);
        queue_frame(eff_w(), eff_h(), 16, 2);
        wait_idle();

        // Tallest frame, only its first rows; the next write drops the rest.
        sender_bursty   = 1'b0;
        receiver_stalls = 1'b0;
        set_reg(REG_FRAME_WIDTH, 32'd1);
        set_reg(REG_FRAME_HEIGHT, 32'd65535);
        queue_frame(eff_w(), eff_h(), 48, 0);
        wait_idle();

        // A last small frame after the restart.
        sender_bursty   = 1'b1;
        receiver_stalls = 1'b1;
        set_reg(REG_FRAME_WIDTH, 32'd5);
        set_reg(REG_FRAME_HEIGHT, 32'd4);
        queue_frame(eff_w(), eff_h(), eff_w() * eff_h(), 10);
        wait_idle();

        $display("Run covered %0d whole frames and %0d register writes, widths 1 to 40",
                 frames_done, reg_writes);
        $display("%0d input words accepted, %0d blurred words checked, %0d mismatches",
                 words_accepted, words_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
